// ----- rtl/sds_pkg.sv -----
// ----------------------------------------------------------------------------
// sds_pkg: shared types and constants of the star-delta starter
// Item and result layouts, operation and fault codes, register indexes.
// ----------------------------------------------------------------------------
package sds_pkg;

  // Operation carried by an input item.
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_START    = 2'd1,
    OP_STOP     = 2'd2,
    OP_EXT_STOP = 2'd3
  } op_t;

  // Fault codes as reported on last_fault.
  localparam logic [3:0] FC_NONE   = 4'd0;
  localparam logic [3:0] FC_OVER   = 4'd1;
  localparam logic [3:0] FC_UNDER  = 4'd2;
  localparam logic [3:0] FC_MANUAL = 4'd3;
  localparam logic [3:0] FC_REMOTE = 4'd4;

  // Voltage check codes.
  localparam logic [1:0] VF_OK   = 2'd0;
  localparam logic [1:0] VF_OVER = 2'd1;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_STAR_DELAY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TIME     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESTART_DELAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_RUN     = 3'd4;

  // Scaling of the delay registers to milliseconds.
  localparam int MS_PER_TENTH  = 100;
  localparam int MS_PER_SECOND = 1000;
  localparam int STAR_MS_W     = 15;   // 255 * 100 fits
  localparam int RESTART_MS_W  = 22;   // 4095 * 1000 fits
  localparam int PRESS_AGE_W   = 16;

  // Register reset values.
  localparam int RST_STAR_TENTHS = 50;
  localparam int RST_DEAD_MS     = 100;
  localparam int RST_RESTART_S   = 60;
  localparam int RST_DEBOUNCE_MS = 50;

  // Configuration as seen by the controller, delays already in ms.
  typedef struct packed {
    logic [STAR_MS_W-1:0]    star_ms;
    logic [9:0]              dead_ms;
    logic [RESTART_MS_W-1:0] restart_ms;
    logic [9:0]              debounce_ms;
    logic                    force_run;
  } cfg_t;

  // Input item, packed so that op sits in the lowest bits.
  typedef struct packed {
    logic [3:0] stop_code;
    logic [3:0] protection_fault;
    logic [1:0] voltage_fault;
    op_t        op;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

  // Result item.
  typedef struct packed {
    logic       running;
    logic [3:0] last_fault;
    logic [2:0] motor_state;
    logic       relay_delta;
    logic       relay_star;
    logic       relay_main;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

// ----- rtl/sds_cfg.sv -----
// ----------------------------------------------------------------------------
// sds_cfg: configuration registers
// Holds the five settings; delays are scaled to milliseconds on write.
// ----------------------------------------------------------------------------
module sds_cfg
  import sds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.star_ms     <= STAR_MS_W'(RST_STAR_TENTHS * MS_PER_TENTH);
      cfg.dead_ms     <= 10'(RST_DEAD_MS);
      cfg.restart_ms  <= RESTART_MS_W'(RST_RESTART_S * MS_PER_SECOND);
      cfg.debounce_ms <= 10'(RST_DEBOUNCE_MS);
      cfg.force_run   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STAR_DELAY:
          cfg.star_ms <= STAR_MS_W'(cfg_data[7:0]) * STAR_MS_W'(MS_PER_TENTH);
        CFG_DEAD_TIME:     cfg.dead_ms <= cfg_data[9:0];
        CFG_RESTART_DELAY:
          cfg.restart_ms <= RESTART_MS_W'(cfg_data) * RESTART_MS_W'(MS_PER_SECOND);
        CFG_DEBOUNCE:      cfg.debounce_ms <= cfg_data[9:0];
        CFG_FORCE_RUN:     cfg.force_run <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/sds_core.sv -----
// ----------------------------------------------------------------------------
// sds_core: starter state machine
// Applies one item to the controller state and registers the result.
// ----------------------------------------------------------------------------
module sds_core
  import sds_pkg::*;
#(
  parameter int AGE_BITS = 22
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  step_en,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  localparam int CMP_W = (AGE_BITS > RESTART_MS_W) ? AGE_BITS : RESTART_MS_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_STAR  = 3'd1,
    ST_DEAD  = 3'd2,
    ST_DELTA = 3'd3,
    ST_FAULT = 3'd4,
    ST_RWAIT = 3'd5
  } state_t;

  state_t                 state, state_next;
  logic [3:0]             fault, fault_next;
  logic                   start_pending, start_pending_next;
  logic                   stop_pending, stop_pending_next;
  logic [AGE_BITS-1:0]    state_age, state_age_next;
  logic [PRESS_AGE_W-1:0] start_age, start_age_next;
  logic [PRESS_AGE_W-1:0] stop_age, stop_age_next;
  logic [AGE_BITS-1:0]    age_inc;
  logic [CMP_W-1:0]       age_cmp;
  res_t                   res_next;

  assign age_inc = (&state_age) ? state_age : state_age + 1'b1;
  assign age_cmp = CMP_W'(age_inc);

  always_comb begin
    state_next         = state;
    fault_next         = fault;
    start_pending_next = start_pending;
    stop_pending_next  = stop_pending;
    state_age_next     = state_age;
    start_age_next     = start_age;
    stop_age_next      = stop_age;

    unique case (item.op)
      OP_TICK: begin
        state_age_next = age_inc;
        start_age_next = (&start_age) ? start_age : start_age + 1'b1;
        stop_age_next  = (&stop_age) ? stop_age : stop_age + 1'b1;
        unique case (state)
          ST_IDLE: begin
            if (start_pending) begin
              start_pending_next = 1'b0;
              state_age_next     = '0;
              if (item.voltage_fault != VF_OK && !cfg.force_run) begin
                fault_next = (item.voltage_fault == VF_OVER) ? FC_OVER : FC_UNDER;
                state_next = ST_FAULT;
              end else begin
                state_next = ST_STAR;
              end
            end
          end
          ST_STAR, ST_DELTA: begin
            if (stop_pending) begin
              stop_pending_next = 1'b0;
              fault_next        = FC_MANUAL;
              state_next        = ST_IDLE;
              state_age_next    = '0;
            end else if (state == ST_STAR) begin
              if (age_cmp >= CMP_W'(cfg.star_ms)) begin
                state_next     = ST_DEAD;
                state_age_next = '0;
              end
            end else if (item.protection_fault != FC_NONE) begin
              fault_next     = item.protection_fault;
              state_next     = ST_FAULT;
              state_age_next = '0;
            end
          end
          ST_DEAD: begin
            if (age_cmp >= CMP_W'(cfg.dead_ms)) begin
              state_next     = ST_DELTA;
              state_age_next = '0;
            end
          end
          ST_FAULT: begin
            if (fault != FC_MANUAL && fault != FC_REMOTE &&
                age_cmp >= CMP_W'(cfg.restart_ms)) begin
              state_next     = ST_RWAIT;
              state_age_next = '0;
            end
            // A manual reset by start press takes precedence over the restart.
            if (start_pending) begin
              start_pending_next = 1'b0;
              fault_next         = FC_NONE;
              state_next         = ST_IDLE;
              state_age_next     = '0;
            end
          end
          ST_RWAIT: begin
            fault_next         = FC_NONE;
            start_pending_next = 1'b1;
            state_next         = ST_IDLE;
            state_age_next     = '0;
          end
          default: begin
            state_next     = ST_IDLE;
            state_age_next = '0;
          end
        endcase
      end
      OP_START: begin
        if (start_age >= PRESS_AGE_W'(cfg.debounce_ms)) begin
          start_age_next = '0;
          if (state == ST_IDLE || state == ST_FAULT) start_pending_next = 1'b1;
        end
      end
      OP_STOP: begin
        if (stop_age >= PRESS_AGE_W'(cfg.debounce_ms)) begin
          stop_age_next     = '0;
          fault_next        = FC_MANUAL;
          stop_pending_next = 1'b1;
        end
      end
      OP_EXT_STOP: begin
        fault_next        = (item.stop_code == FC_NONE) ? FC_MANUAL : item.stop_code;
        stop_pending_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_next.relay_main  = (state_next == ST_STAR) || (state_next == ST_DEAD) ||
                           (state_next == ST_DELTA);
    res_next.relay_star  = (state_next == ST_STAR);
    res_next.relay_delta = (state_next == ST_DELTA);
    res_next.motor_state = state_next;
    res_next.last_fault  = fault_next;
    res_next.running     = (state_next == ST_STAR) || (state_next == ST_DELTA);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fault         <= FC_NONE;
      start_pending <= 1'b0;
      stop_pending  <= 1'b0;
      state_age     <= '0;
      start_age     <= '0;
      stop_age      <= '0;
    end else if (step_en) begin
      state         <= state_next;
      fault         <= fault_next;
      start_pending <= start_pending_next;
      stop_pending  <= stop_pending_next;
      state_age     <= state_age_next;
      start_age     <= start_age_next;
      stop_age      <= stop_age_next;
      res           <= res_next;
    end
  end

endmodule

// ----- rtl/star_delta_starter_fsm.sv -----
// ----------------------------------------------------------------------------
// star_delta_starter_fsm: star-delta motor starter sequencer
// Path: an accepted item waits in the input register until the controller
// steps, which loads its result into the result register.
// Throughput: one item per cycle unless back pressure stalls the controller step.
// Reset (rst, synchronous, active high) returns the controller to idle with
// no fault, clears both pipeline stages and restores the register defaults.
// ----------------------------------------------------------------------------
//
// Each input item is a 1 ms tick, a start or stop button press, or an
// external stop. The item is first captured in an input register. When that
// register can move on, the controller step in sds_core applies it to the
// state and loads the result register in the same edge. Back pressure on the
// master side stalls the input register; the input still accepts a transfer
// in the cycle that the waiting result is taken, so a stream with tready held
// high runs at one item per clock.
//
// Timing is carried in milliseconds: the star delay (tenths of a second) and
// restart delay (seconds) are scaled to milliseconds when written, so the
// controller only compares its state age against ready-made thresholds.
module star_delta_starter_fsm
  import sds_pkg::*;
#(
  parameter int AGE_BITS = 22
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata from bit 0: op[1:0], voltage_fault[3:2], protection_fault[7:4],
  // stop_code[11:8], zero padding[15:12]
  input  logic [15:0]           s_tdata,
  // Result stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata from bit 0: relay_main[0], relay_star[1], relay_delta[2],
  // motor_state[5:3], last_fault[9:6], running[10], zero padding[15:11]
  output logic [15:0]           m_tdata
);

  cfg_t  cfg;
  item_t in_item;
  logic  in_valid;
  logic  out_valid;
  logic  advance;
  res_t  res;

  // The held item moves into the controller when the result register is
  // empty or its contents are being taken in this cycle.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (advance) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  // Payload of the input stage; no reset needed.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_item <= item_t'(s_tdata[ITEM_W-1:0]);
  end

  sds_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sds_core #(
    .AGE_BITS (AGE_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .item    (in_item),
    .cfg     (cfg),
    .res     (res)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {(16 - RES_W)'(0), res};

endmodule

// ----- bench/tb_star_delta_starter_fsm.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_star_delta_starter_fsm: self-checking bench for the star-delta starter
// Drives button, tick and external stop items into the input stream and keeps
// its own model of the starter sequence. Every result on the output stream is
// compared field by field with the status that the model expects.
// ----------------------------------------------------------------------------
module tb_star_delta_starter_fsm;
  import sds_pkg::*;

  localparam int  AGE_BITS   = 22;
  localparam int  CLK_HALF   = 6;
  localparam longint TIMEOUT_NS = 64'd20_000_000;

  // Undervoltage has two encodings: value two, and value three which the
  // starter treats in the same way.
  localparam logic [1:0] VF_UNDER     = 2'd2;
  localparam logic [1:0] VF_UNDER_ALT = 2'd3;
  // Highest protection code listed, and the widest code the field can carry.
  localparam logic [3:0] FC_PROT_LAST = 4'd13;
  localparam logic [3:0] FC_PROT_WIDE = 4'd15;

  // Controller states as they appear on motor_state.
  typedef enum logic [2:0] {
    MS_IDLE    = 3'd0,
    MS_STAR    = 3'd1,
    MS_DEAD    = 3'd2,
    MS_DELTA   = 3'd3,
    MS_FAULT   = 3'd4,
    MS_RESTART = 3'd5
  } motor_state_t;

  // Ways in which the result side holds off transfers.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_COMB,
    RX_BLOCKS
  } rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;

  star_delta_starter_fsm #(
    .AGE_BITS(AGE_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin : clock_gen
    forever #(CLK_HALF) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Starter model. The registers below mirror the block's configuration and
  // controller state; they start at the values the block takes on reset.
  // --------------------------------------------------------------------------
  logic [7:0]          cfg_star_tenths = 8'(RST_STAR_TENTHS);
  logic [9:0]          cfg_dead_ms     = 10'(RST_DEAD_MS);
  logic [11:0]         cfg_restart_s   = 12'(RST_RESTART_S);
  logic [9:0]          cfg_debounce    = 10'(RST_DEBOUNCE_MS);
  logic                cfg_force       = 1'b0;

  motor_state_t        motor_st     = MS_IDLE;
  logic [3:0]          fault_code   = FC_NONE;
  logic                start_req    = 1'b0;
  logic                stop_req     = 1'b0;
  logic [AGE_BITS-1:0] age_in_state = '0;
  logic [PRESS_AGE_W-1:0] start_age = '0;
  logic [PRESS_AGE_W-1:0] stop_age  = '0;

  // Statuses still owed by the block, oldest first.
  res_t pending_status[$];
  int   error_count = 0;
  int   burst_left  = 0;

  function automatic void move_to(input motor_state_t next_st);
    motor_st     = next_st;
    age_in_state = '0;
  endfunction

  // One controller step, taken on every millisecond tick after the ages have
  // advanced.
  function automatic void controller_tick(input logic [1:0] vf, input logic [3:0] pf);
    case (motor_st)
      MS_IDLE: begin
        if (start_req) begin
          start_req = 1'b0;
          // A bad supply blocks the start unless force-run is set.
          if (vf != VF_OK && !cfg_force) begin
            fault_code = (vf == VF_OVER) ? FC_OVER : FC_UNDER;
            move_to(MS_FAULT);
          end else begin
            move_to(MS_STAR);
          end
        end
      end
      MS_STAR: begin
        if (stop_req) begin
          stop_req   = 1'b0;
          fault_code = FC_MANUAL;
          move_to(MS_IDLE);
        end else if (int'(age_in_state) >= int'(cfg_star_tenths) * MS_PER_TENTH) begin
          move_to(MS_DEAD);
        end
      end
      MS_DEAD: begin
        if (int'(age_in_state) >= int'(cfg_dead_ms)) move_to(MS_DELTA);
      end
      MS_DELTA: begin
        if (stop_req) begin
          stop_req   = 1'b0;
          fault_code = FC_MANUAL;
          move_to(MS_IDLE);
        end else if (pf != FC_NONE) begin
          fault_code = pf;
          move_to(MS_FAULT);
        end
      end
      MS_FAULT: begin
        // The automatic restart is checked first; a pending start then wins
        // over it on the same tick.
        if (fault_code != FC_MANUAL && fault_code != FC_REMOTE &&
            int'(age_in_state) >= int'(cfg_restart_s) * MS_PER_SECOND)
          move_to(MS_RESTART);
        if (start_req) begin
          start_req  = 1'b0;
          fault_code = FC_NONE;
          move_to(MS_IDLE);
        end
      end
      MS_RESTART: begin
        fault_code = FC_NONE;
        start_req  = 1'b1;
        move_to(MS_IDLE);
      end
      default: move_to(MS_IDLE);
    endcase
  endfunction

  // Applies one item to the model and returns the status the block reports.
  function automatic res_t starter_step(input item_t it);
    res_t st;
    case (it.op)
      OP_TICK: begin
        if (age_in_state != '1) age_in_state++;
        if (start_age != '1) start_age++;
        if (stop_age != '1) stop_age++;
        controller_tick(it.voltage_fault, it.protection_fault);
      end
      OP_START: begin
        // The debounce age is cleared even when the state drops the request.
        if (start_age >= cfg_debounce) begin
          start_age = '0;
          if (motor_st == MS_IDLE || motor_st == MS_FAULT) start_req = 1'b1;
        end
      end
      OP_STOP: begin
        if (stop_age >= cfg_debounce) begin
          stop_age   = '0;
          fault_code = FC_MANUAL;
          stop_req   = 1'b1;
        end
      end
      default: begin
        // External stops bypass the debounce; code zero reads as manual.
        fault_code = (it.stop_code == FC_NONE) ? FC_MANUAL : it.stop_code;
        stop_req   = 1'b1;
      end
    endcase
    st.relay_main  = motor_st inside {MS_STAR, MS_DEAD, MS_DELTA};
    st.relay_star  = (motor_st == MS_STAR);
    st.relay_delta = (motor_st == MS_DELTA);
    st.motor_state = motor_st;
    st.last_fault  = fault_code;
    st.running     = motor_st inside {MS_STAR, MS_DELTA};
    return st;
  endfunction

  // --------------------------------------------------------------------------
  // Input side. Items go out in bursts of random length with random gaps in
  // between; some bursts follow on with no gap at all. s_tvalid stays high
  // from one item to the next inside a burst.
  // --------------------------------------------------------------------------
  task automatic send_item(input item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, it};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // The transfer has happened at this edge: predict its status now, so that
    // the expected statuses stay in transfer order.
    pending_status.push_back(starter_step(it));
    burst_left--;
  endtask

  task automatic send_op(input op_t op, input logic [1:0] vf, input logic [3:0] pf,
                         input logic [3:0] sc);
    item_t it;
    it.op               = op;
    it.voltage_fault    = vf;
    it.protection_fault = pf;
    it.stop_code        = sc;
    send_item(it);
  endtask

  // A tick with random content that keeps the sequence moving: the supply is
  // good whenever a start is about to be taken, and no protection fault is
  // raised while in delta.
  task automatic send_quiet_tick();
    send_op(OP_TICK,
            (motor_st == MS_IDLE && start_req) ? VF_OK : 2'($urandom_range(0, 3)),
            (motor_st == MS_DELTA) ? FC_NONE : 4'($urandom_range(0, 15)),
            4'($urandom_range(0, 15)));
  endtask

  // Lets the stream run dry and every owed status arrive, then a few spare
  // cycles for the two-stage pipeline.
  task automatic settle();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      CFG_STAR_DELAY:    cfg_star_tenths = value[7:0];
      CFG_DEAD_TIME:     cfg_dead_ms     = value[9:0];
      CFG_RESTART_DELAY: cfg_restart_s   = value[11:0];
      CFG_DEBOUNCE:      cfg_debounce    = value[9:0];
      CFG_FORCE_RUN:     cfg_force       = value[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Writes the full register set; only ever done with the block idle.
  task automatic program_timing(input int star_tenths, input int dead_ms,
                                input int restart_s, input int debounce_ms,
                                input int force_run);
    settle();
    write_reg(CFG_STAR_DELAY, star_tenths);
    write_reg(CFG_DEAD_TIME, dead_ms);
    write_reg(CFG_RESTART_DELAY, restart_s);
    write_reg(CFG_DEBOUNCE, debounce_ms);
    write_reg(CFG_FORCE_RUN, force_run);
  endtask

  // --------------------------------------------------------------------------
  // Output side. The stall pattern is drawn anew whenever the low six bits of
  // rx_cycle are zero: always ready, random, a fixed comb or long blocks of stall.
  // --------------------------------------------------------------------------
  rx_mode_t    rx_mode  = RX_OPEN;
  int unsigned rx_cycle = 0;

  always @(posedge clk) begin : rx_stall_pattern
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle[5:0] == 6'd0) rx_mode <= rx_mode_t'(2'($urandom_range(0, 3)));
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_RANDOM: m_tready <= ($urandom_range(0, 9) < 7);
      RX_COMB:   m_tready <= ((rx_cycle % 5) < 2);
      default:   m_tready <= rx_cycle[3];
    endcase
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Every result transfer is matched against the oldest owed status.
  always @(posedge clk) begin : status_check
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[RES_W-1:0];
      if (pending_status.size() == 0) begin
        $error("result transfer with no status owed: 0x%04h", m_tdata);
        error_count++;
      end else begin
        want = pending_status.pop_front();
        check_field("relay_main", want.relay_main, got.relay_main);
        check_field("relay_star", want.relay_star, got.relay_star);
        check_field("relay_delta", want.relay_delta, got.relay_delta);
        check_field("motor_state", want.motor_state, got.motor_state);
        check_field("last_fault", want.last_fault, got.last_fault);
        check_field("running", want.running, got.running);
        check_field("padding", 0, m_tdata[15:RES_W]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked items: presses inside the first debounce window, every
  // operation, both voltage faults and the value three, force-run, protection
  // codes beyond the listed range, remote stops that suppress the restart, and
  // a restart falling due on the same tick as a manual reset.
  task automatic test_directed();
    // Register defaults: both presses come too early and are dropped.
    send_op(OP_START, VF_OK, FC_NONE, FC_NONE);
    send_op(OP_STOP, VF_OK, FC_NONE, FC_NONE);
    // An external stop with code zero counts as manual and stays pending.
    send_op(OP_EXT_STOP, VF_OK, FC_NONE, FC_NONE);
    send_op(OP_TICK, VF_UNDER_ALT, FC_PROT_WIDE, FC_PROT_WIDE);

    program_timing(0, 0, 0, 0, 0);
    send_op(OP_START, VF_OK, FC_NONE, FC_NONE);
    send_op(OP_TICK, VF_UNDER_ALT, FC_NONE, FC_NONE);   // undervoltage trip
    send_op(OP_TICK, VF_OK, FC_NONE, FC_NONE);          // restart due at once
    send_op(OP_TICK, VF_OK, FC_NONE, FC_NONE);          // back to idle, start owed
    send_op(OP_TICK, VF_OK, FC_NONE, FC_NONE);          // into star
    send_op(OP_TICK, VF_OK, FC_NONE, FC_NONE);          // the old stop acts here
    send_op(OP_START, VF_OK, FC_NONE, FC_NONE);
    send_op(OP_TICK, VF_OVER, FC_NONE, FC_NONE);        // overvoltage trip
    send_op(OP_START, VF_OK, FC_NONE, FC_NONE);
    send_op(OP_TICK, VF_OK, FC_NONE, FC_NONE);          // restart and reset together

    program_timing(0, 0, 0, 0, 1);
    send_op(OP_START, VF_OK, FC_NONE, FC_NONE);
    send_op(OP_TICK, VF_UNDER, FC_NONE, FC_NONE);       // force-run ignores it
    send_op(OP_START, VF_OK, FC_NONE, FC_NONE);         // dropped in star
    send_op(OP_TICK, VF_OK, FC_NONE, FC_NONE);
    send_op(OP_TICK, VF_OK, FC_NONE, FC_NONE);
    send_op(OP_TICK, VF_OK, FC_PROT_WIDE, FC_NONE);     // trips with code fifteen
    send_op(OP_EXT_STOP, VF_OK, FC_NONE, FC_REMOTE);
    send_op(OP_TICK, VF_OK, FC_NONE, FC_NONE);          // remote stop: no restart
    send_op(OP_START, VF_OK, FC_NONE, FC_NONE);
    send_op(OP_TICK, VF_OK, FC_NONE, FC_NONE);
    send_op(OP_STOP, VF_UNDER_ALT, FC_PROT_WIDE, FC_PROT_WIDE);
  endtask

  // The longest star period, a 1000 ms dead time and a one-second restart delay.
  // A supply trip is held in fault for the full second, the restart then runs
  // into a stop that is still owed, and a second start sits in star far short
  // of its 25.5 s. With the debounce raised to a full second, a quick second
  // press is dropped.
  task automatic test_extremes();
    program_timing(255, 1000, 1, 0, 0);
    send_op(OP_START, VF_OK, FC_NONE, FC_NONE);
    send_op(OP_TICK, VF_UNDER, FC_NONE, FC_NONE);
    // Ride out the restart delay; the cap keeps a wrong turn from running on.
    for (int n = 0; n < 1100 && motor_st == MS_FAULT; n++) send_quiet_tick();
    repeat (3) send_quiet_tick();
    settle();
    write_reg(CFG_DEBOUNCE, 1000);
    send_op(OP_START, VF_OK, FC_NONE, FC_NONE);
    send_quiet_tick();
    send_op(OP_START, VF_OK, FC_NONE, FC_NONE);         // inside the debounce window
    repeat (60) send_quiet_tick();
    send_op(OP_EXT_STOP, VF_OK, FC_NONE, FC_NONE);
    send_quiet_tick();
    send_op(OP_TICK, VF_OK, FC_PROT_LAST, FC_NONE);
  endtask

  // Mostly plausible traffic: ticks with a good supply and only the odd
  // protection fault, sprinkled with presses and external stops. About one
  // item in eight is pure noise across every field.
  function automatic item_t draw_item();
    item_t it;
    int    pick;
    it.op               = OP_TICK;
    it.voltage_fault    = VF_OK;
    it.protection_fault = FC_NONE;
    it.stop_code        = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < 12) begin
      it.op               = op_t'(2'($urandom_range(0, 3)));
      it.voltage_fault    = 2'($urandom_range(0, 3));
      it.protection_fault = 4'($urandom_range(0, 15));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        if ($urandom_range(0, 9) == 0) it.voltage_fault = 2'($urandom_range(1, 3));
        if ($urandom_range(0, 29) == 0) it.protection_fault = 4'($urandom_range(1, 15));
      end else if (pick < 90) begin
        it.op = OP_START;
      end else if (pick < 96) begin
        it.op = OP_STOP;
      end else begin
        it.op = OP_EXT_STOP;
      end
    end
    return it;
  endfunction

  task automatic test_random();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        // Everything as short as it gets.
        0: program_timing(0, 0, 0, 0, 1);
        // A one-second restart delay next to short star and dead times.
        1: program_timing(1, 3, 1, 2, 0);
        default: program_timing($urandom_range(0, 2), $urandom_range(0, 30),
                                ($urandom_range(0, 3) == 0) ? 1 : 0,
                                $urandom_range(0, 8), $urandom_range(0, 1));
      endcase
      repeat (70) send_item(draw_item());
    end
  endtask

  initial begin : timeout_guard
    #(TIMEOUT_NS);
    $display("star_delta_starter_fsm test failed");
    $finish;
  end

  initial begin : run_tests
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extremes();
    test_random();
    settle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("star_delta_starter_fsm test passed");
    end else begin
      $display("star_delta_starter_fsm test failed");
    end
    $finish;
  end

endmodule
